>>> rtl/core/trimmed_mean_distance_filter_top_macros.svh
// Assertion macros shared by the checker of the trimmed-mean distance filter.
`ifndef TRIMMED_MEAN_DISTANCE_FILTER_TOP_MACROS_SVH
`define TRIMMED_MEAN_DISTANCE_FILTER_TOP_MACROS_SVH

// Consequent must hold in the cycle after the antecedent.
`define TMDF_ASSERT_NEXT(label, clk, rst, ante, cons) \
    label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
        else $error("tmdf assertion failed");

// Consequent must hold in the same cycle as the antecedent.
`define TMDF_ASSERT_SAME(label, clk, rst, ante, cons) \
    label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
        else $error("tmdf assertion failed");

`endif

>>> rtl/core/tmdf_pkg.sv
// Package with types and constants of the trimmed-mean distance filter.
`default_nettype none
package tmdf_pkg;

    localparam int RING_DEPTH_DEF = 10;
    localparam int FILL_VALUE_DEF = 800;

    localparam int RAW_W     = 16;
    localparam int DIST_W    = 10;
    localparam int LIMIT_W   = 4;
    localparam int CNT_W     = 5;
    localparam int CFG_IDX_W = 3;
    localparam int OUT_TDATA_W = 16;

    localparam logic [DIST_W-1:0]  CLAMP_LIMIT_RST  = DIST_W'(1000);
    localparam logic [DIST_W-1:0]  CLAMP_SUBST_RST  = DIST_W'(800);
    localparam logic [DIST_W-1:0]  ERROR_DIST_RST   = DIST_W'(1000);
    localparam logic [DIST_W-1:0]  NEAR_THRESH_RST  = DIST_W'(425);
    localparam logic [LIMIT_W-1:0] FAIL_LIMIT_RST   = LIMIT_W'(5);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CLAMP_LIMIT = 3'd0,
        CFG_CLAMP_SUBST = 3'd1,
        CFG_ERROR_DIST  = 3'd2,
        CFG_NEAR_THRESH = 3'd3,
        CFG_FAIL_LIMIT  = 3'd4
    } t_cfg_idx;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_LAST,
        S_TRIM,
        S_DIV,
        S_RES
    } t_state;

endpackage
`default_nettype wire

>>> rtl/core/trimmed_mean_distance_filter_top.sv
// Top level of the trimmed-mean distance filter.
//
// One input transaction on the s_axis channel carries a 16-bit distance word in
// tdata and the read-success flag in tuser. One output transaction on the
// m_axis channel follows for each input, in order. Registers are written on
// the cfg channel, which is always ready; the user must write them only while
// the block is idle, which the block itself does not enforce. A failed read
// goes from acceptance through the result state to the output register, and
// the next input transaction can follow once that result is registered.
// A good read is written to the ring memory in the cycle of acceptance, then
// the ring is read back one entry per cycle for minimum, maximum and sum, and
// a multiplication by the scaled reciprocal of RING_DEPTH minus two forms the
// trimmed mean: the scan, last, trim, divide and result states lead to the
// output register, and the next input transaction can follow once the result
// is registered. One item is in work at a time.
// The output register parts the channels: s_tready returns as soon as the
// result is registered, even while the receiver stalls it; a further result
// waits in its final state until the output register is free.
// Reset returns every ring entry to the fill value through per-entry valid
// bits, so no clearing pass is needed, and restores the register defaults.
`default_nettype none
module trimmed_mean_distance_filter_top
    import tmdf_pkg::*;
#(
    parameter int RING_DEPTH = RING_DEPTH_DEF,
    parameter int FILL_VALUE = FILL_VALUE_DEF
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_s_tvalid,
    output logic                        o_s_tready,
    // tdata: raw_distance[15:0]
    input  wire logic [RAW_W-1:0]       i_s_tdata,
    // tuser: read_ok[0]
    input  wire logic                   i_s_tuser,
    output logic                        o_m_tvalid,
    input  wire logic                   i_m_tready,
    // tdata: filtered_distance[9:0], near_flag[10], fault_flag[11],
    // power_cycle_request[12], zero[15:13]
    output logic [OUT_TDATA_W-1:0]      o_m_tdata,
    // tuser: reading_valid[0]
    output logic                        o_m_tuser,
    input  wire logic                   i_cfg_valid,
    output logic                        o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]   i_cfg_index,
    input  wire logic [DIST_W-1:0]      i_cfg_data
);

    localparam int ADDR_W = $clog2(RING_DEPTH);
    localparam int SUM_W  = $clog2(RING_DEPTH * 1024);
    localparam logic [DIST_W-1:0] FILL_C = DIST_W'(FILL_VALUE);
    localparam logic [ADDR_W-1:0] LAST_A = ADDR_W'(RING_DEPTH - 1);

    t_state r_state;
    t_state n_state;

    logic [DIST_W-1:0]  r_clamp_limit;
    logic [DIST_W-1:0]  r_clamp_subst;
    logic [DIST_W-1:0]  r_error_dist;
    logic [DIST_W-1:0]  r_near_thresh;
    logic [LIMIT_W-1:0] r_fail_limit;

    logic [RING_DEPTH-1:0] r_vld;
    logic [ADDR_W-1:0]     r_slot;
    logic [ADDR_W-1:0]     r_addr;
    logic                  r_pend;
    logic                  r_rd_fill;
    logic [CNT_W-1:0]      r_fail_cnt;
    logic                  r_fault;

    logic [DIST_W-1:0] r_lo;
    logic [DIST_W-1:0] r_hi;
    logic [SUM_W-1:0]  r_sum;
    logic [DIST_W-1:0] r_dist;
    logic              r_ok;

    logic                   r_m_valid;
    logic [OUT_TDATA_W-1:0] r_m_data;
    logic                   r_m_user;

    logic              s_acc;
    logic              cfg_acc;
    logic              ram_we;
    logic [DIST_W-1:0] wr_val;
    logic [DIST_W-1:0] ram_q;
    logic [DIST_W-1:0] rd_val;
    logic              div_start;
    logic              div_done;
    logic [SUM_W-1:0]  div_quot;
    logic [SUM_W-1:0]  trim_sum;
    logic              res_load;
    logic [CNT_W-1:0]  cnt_inc;
    logic              fail_over;
    logic [CNT_W-1:0]  n_fail_cnt;
    logic              n_fault;
    logic              near;

    assign o_cfg_ready = 1'b1;
    assign cfg_acc     = i_cfg_valid;
    assign s_acc       = i_s_tvalid && o_s_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clamp_limit <= CLAMP_LIMIT_RST;
            r_clamp_subst <= CLAMP_SUBST_RST;
            r_error_dist  <= ERROR_DIST_RST;
            r_near_thresh <= NEAR_THRESH_RST;
            r_fail_limit  <= FAIL_LIMIT_RST;
        end else if (cfg_acc) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_CLAMP_LIMIT: r_clamp_limit <= i_cfg_data;
                CFG_CLAMP_SUBST: r_clamp_subst <= i_cfg_data;
                CFG_ERROR_DIST:  r_error_dist  <= i_cfg_data;
                CFG_NEAR_THRESH: r_near_thresh <= i_cfg_data;
                CFG_FAIL_LIMIT:  r_fail_limit  <= i_cfg_data[LIMIT_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (s_acc) begin
                    n_state = i_s_tuser ? S_SCAN : S_RES;
                end
            end
            S_SCAN: begin
                if (r_addr == LAST_A) begin
                    n_state = S_LAST;
                end
            end
            S_LAST: n_state = S_TRIM;
            S_TRIM: n_state = S_DIV;
            S_DIV: begin
                if (div_done) begin
                    n_state = S_RES;
                end
            end
            S_RES: begin
                if (!r_m_valid || i_m_tready) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_s_tready = (r_state == S_IDLE);
        div_start  = (r_state == S_TRIM);
        res_load   = (r_state == S_RES) && (!r_m_valid || i_m_tready);
        ram_we     = s_acc && i_s_tuser;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign wr_val = ({6'd0, r_clamp_limit} < i_s_tdata) ? r_clamp_subst
                                                       : i_s_tdata[DIST_W-1:0];

    tmdf_ram #(
        .WIDTH(DIST_W),
        .DEPTH(RING_DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_slot),
        .i_wdata (wr_val),
        .i_raddr (r_addr),
        .o_rdata (ram_q)
    );

    assign rd_val = r_rd_fill ? FILL_C : ram_q;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld  <= '0;
            r_slot <= '0;
            r_addr <= '0;
            r_pend <= 1'b0;
        end else begin
            r_pend <= (r_state == S_SCAN);
            if (ram_we) begin
                r_vld[r_slot] <= 1'b1;
                r_slot        <= (r_slot == LAST_A) ? '0 : r_slot + ADDR_W'(1);
            end
            if (r_state == S_SCAN) begin
                r_addr <= (r_addr == LAST_A) ? '0 : r_addr + ADDR_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_fill <= !r_vld[r_addr];
        if (s_acc) begin
            r_lo   <= '1;
            r_hi   <= '0;
            r_sum  <= '0;
            r_ok   <= i_s_tuser;
            r_dist <= r_error_dist;
        end else begin
            if (r_pend) begin
                if (rd_val < r_lo) begin
                    r_lo <= rd_val;
                end
                if (rd_val > r_hi) begin
                    r_hi <= rd_val;
                end
                r_sum <= r_sum + SUM_W'(rd_val);
            end
            if (div_done) begin
                r_dist <= div_quot[DIST_W-1:0];
            end
        end
    end

    assign trim_sum = r_sum - SUM_W'(r_lo) - SUM_W'(r_hi);

    tmdf_div #(
        .W       (SUM_W),
        .DIVISOR (RING_DEPTH - 2)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (trim_sum),
        .o_quot     (div_quot),
        .o_done     (div_done)
    );

    always_comb begin
        cnt_inc    = r_fail_cnt + CNT_W'(1);
        fail_over  = (cnt_inc > {1'b0, r_fail_limit});
        n_fail_cnt = r_fail_cnt;
        n_fault    = r_fault;
        if (r_ok) begin
            if (r_fault) begin
                n_fail_cnt = '0;
                n_fault    = 1'b0;
            end
        end else begin
            n_fail_cnt = fail_over ? '0 : cnt_inc;
            n_fault    = fail_over ? 1'b1 : r_fault;
        end
        near = r_ok && (r_dist <= r_near_thresh);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fail_cnt <= '0;
            r_fault    <= 1'b0;
            r_m_valid  <= 1'b0;
        end else begin
            if (res_load) begin
                r_fail_cnt <= n_fail_cnt;
                r_fault    <= n_fault;
                r_m_valid  <= 1'b1;
            end else if (i_m_tready) begin
                r_m_valid  <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_load) begin
            r_m_data <= {3'd0, !r_ok, n_fault, near, r_dist};
            r_m_user <= r_ok;
        end
    end

    assign o_m_tvalid = r_m_valid;
    assign o_m_tdata  = r_m_data;
    assign o_m_tuser  = r_m_user;

endmodule
`default_nettype wire

>>> rtl/core/tmdf_ram.sv
// Generic single-write, single-read RAM with a registered read port.
`default_nettype none
module tmdf_ram #(
    parameter int WIDTH = 10,
    parameter int DEPTH = 10
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule
`default_nettype wire

>>> rtl/core/tmdf_div.sv
// Divider by a constant through multiplication with a scaled reciprocal.
`default_nettype none
module tmdf_div #(
    parameter int W       = 14,
    parameter int DIVISOR = 8
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_start,
    input  wire logic [W-1:0] i_dividend,
    output logic      [W-1:0] o_quot,
    output logic              o_done
);

    localparam int SHIFT = W + $clog2(DIVISOR);
    localparam int RW    = W + 1;
    localparam int PW    = W + RW;
    localparam longint unsigned RECIP_L =
        ((64'd1 << SHIFT) + 64'(DIVISOR) - 64'd1) / 64'(DIVISOR);
    localparam logic [RW-1:0] RECIP = RW'(RECIP_L);

    logic          r_busy;
    logic          r_done;
    logic [W-1:0]  r_x;
    logic [W-1:0]  r_q;
    logic [PW-1:0] prod;

    assign prod = PW'(r_x) * PW'(RECIP);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= i_start;
            r_done <= r_busy;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_x <= i_dividend;
        end
        if (r_busy) begin
            r_q <= W'(prod >> SHIFT);
        end
    end

    assign o_quot = r_q;
    assign o_done = r_done;

endmodule
`default_nettype wire

>>> rtl/core/tmdf_checker.sv
// Port-level checker of the trimmed-mean distance filter and its bind.
`default_nettype none
`include "trimmed_mean_distance_filter_top_macros.svh"
module tmdf_checker
    import tmdf_pkg::*;
(
    input wire logic                   i_clk,
    input wire logic                   i_rst_n,
    input wire logic                   i_s_tvalid,
    input wire logic                   o_s_tready,
    input wire logic                   o_m_tvalid,
    input wire logic                   i_m_tready,
    input wire logic [OUT_TDATA_W-1:0] o_m_tdata,
    input wire logic                   o_m_tuser
);

    `TMDF_ASSERT_NEXT(a_out_hold, i_clk, !i_rst_n, o_m_tvalid && !i_m_tready, o_m_tvalid && $stable(o_m_tdata))
    `TMDF_ASSERT_NEXT(a_rst_clear, i_clk, 1'b0, !i_rst_n, !o_m_tvalid)
    `TMDF_ASSERT_NEXT(a_one_item, i_clk, !i_rst_n, i_s_tvalid && o_s_tready, !o_s_tready)
    `TMDF_ASSERT_SAME(a_good_flags, i_clk, !i_rst_n, o_m_tvalid && o_m_tuser, !o_m_tdata[12] && (o_m_tdata[15:13] == 3'd0))

endmodule

bind trimmed_mean_distance_filter_top tmdf_checker u_tmdf_checker (.*);
`default_nettype wire

>>> tb/tmdf_output_check.sv
// Output checker for the trimmed-mean distance filter: predicts every result and compares it.
`timescale 1ns / 100ps
module tmdf_output_check
    import tmdf_pkg::*;
(
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_s_tvalid,
    input  wire logic                   o_s_tready,
    input  wire logic [RAW_W-1:0]       i_s_tdata,
    input  wire logic                   i_s_tuser,
    input  wire logic                   o_m_tvalid,
    input  wire logic                   i_m_tready,
    input  wire logic [OUT_TDATA_W-1:0] o_m_tdata,
    input  wire logic                   o_m_tuser,
    input  wire logic                   i_cfg_valid,
    input  wire logic                   o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]   i_cfg_index,
    input  wire logic [DIST_W-1:0]      i_cfg_data,
    output int                          o_mismatches,
    output int                          o_awaited
);

    typedef struct packed {
        logic [DIST_W-1:0] distance;
        logic              valid;
        logic              near;
        logic              fault;
        logic              power_cycle;
    } t_filter_result;

    logic [DIST_W-1:0]  clamp_limit;
    logic [DIST_W-1:0]  clamp_subst;
    logic [DIST_W-1:0]  error_dist;
    logic [DIST_W-1:0]  near_thresh;
    logic [LIMIT_W-1:0] fail_limit;

    logic [DIST_W-1:0]  ring [RING_DEPTH_DEF];
    int                 slot;
    logic [CNT_W-1:0]   fail_cnt;
    logic               fault;

    t_filter_result     awaited_results [$];
    t_filter_result     want;

    initial begin
        o_mismatches = 0;
        o_awaited = 0;
    end

    function automatic t_filter_result filter_reading(input logic [RAW_W-1:0] raw,
                                                      input logic ok);
        t_filter_result    r;
        logic [DIST_W-1:0] stored;
        logic [DIST_W-1:0] lo;
        logic [DIST_W-1:0] hi;
        int unsigned       total;
        r = '0;
        if (ok) begin
            stored = (raw > clamp_limit) ? clamp_subst : raw[DIST_W-1:0];
            ring[slot] = stored;
            slot = (slot == RING_DEPTH_DEF - 1) ? 0 : slot + 1;
            lo = '1;
            hi = '0;
            total = 0;
            foreach (ring[k]) begin
                if (ring[k] < lo) lo = ring[k];
                if (ring[k] > hi) hi = ring[k];
                total += ring[k];
            end
            r.distance = DIST_W'((total - lo - hi) / (RING_DEPTH_DEF - 2));
            r.valid = 1'b1;
            r.near = (r.distance <= near_thresh);
            if (fault) begin
                fault = 1'b0;
                fail_cnt = '0;
            end
        end else begin
            r.distance = error_dist;
            r.power_cycle = 1'b1;
            fail_cnt = fail_cnt + 1'b1;
            if (fail_cnt > fail_limit) begin
                fail_cnt = '0;
                fault = 1'b1;
            end
        end
        r.fault = fault;
        return r;
    endfunction

    task automatic compare_field(input string name, input int unsigned exp_val,
                                 input int unsigned act_val);
        if (exp_val != act_val) begin
            $error("%s mismatch: expected %0d, got %0d", name, exp_val, act_val);
            o_mismatches++;
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            clamp_limit = CLAMP_LIMIT_RST;
            clamp_subst = CLAMP_SUBST_RST;
            error_dist = ERROR_DIST_RST;
            near_thresh = NEAR_THRESH_RST;
            fail_limit = FAIL_LIMIT_RST;
            foreach (ring[k]) ring[k] = DIST_W'(FILL_VALUE_DEF);
            slot = 0;
            fail_cnt = '0;
            fault = 1'b0;
            awaited_results.delete();
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                case (t_cfg_idx'(i_cfg_index))
                    CFG_CLAMP_LIMIT: clamp_limit = i_cfg_data;
                    CFG_CLAMP_SUBST: clamp_subst = i_cfg_data;
                    CFG_ERROR_DIST:  error_dist = i_cfg_data;
                    CFG_NEAR_THRESH: near_thresh = i_cfg_data;
                    CFG_FAIL_LIMIT:  fail_limit = i_cfg_data[LIMIT_W-1:0];
                    default: ;
                endcase
            end
            if (i_s_tvalid && o_s_tready)
                awaited_results.push_back(filter_reading(i_s_tdata, i_s_tuser));
            if (o_m_tvalid && i_m_tready) begin
                if (awaited_results.size() == 0) begin
                    $error("Output transaction arrived with no result awaited: tdata %0h",
                           o_m_tdata);
                    o_mismatches++;
                end else begin
                    want = awaited_results.pop_front();
                    compare_field("filtered_distance", 32'(want.distance),
                                  32'(o_m_tdata[DIST_W-1:0]));
                    compare_field("reading_valid", 32'(want.valid), 32'(o_m_tuser));
                    compare_field("near_flag", 32'(want.near), 32'(o_m_tdata[DIST_W]));
                    compare_field("fault_flag", 32'(want.fault), 32'(o_m_tdata[DIST_W+1]));
                    compare_field("power_cycle_request", 32'(want.power_cycle),
                                  32'(o_m_tdata[DIST_W+2]));
                    compare_field("tdata_padding", 0,
                                  32'(o_m_tdata[OUT_TDATA_W-1:DIST_W+3]));
                end
            end
        end
        o_awaited = awaited_results.size();
    end

endmodule

>>> tb/trimmed_mean_distance_filter_top_tb.sv
// Testbench top for the trimmed-mean distance filter: stimulus, configuration and verdict.
`timescale 1ns / 100ps
module trimmed_mean_distance_filter_top_tb;
    import tmdf_pkg::*;

    localparam int QUIET_LIMIT   = 2000;
    localparam int HOLD_CYCLES   = 300;
    localparam int SETTLE_CYCLES = 40;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   i_s_tvalid = 1'b0;
    logic                   o_s_tready;
    logic [RAW_W-1:0]       i_s_tdata = '0;
    logic                   i_s_tuser = 1'b0;
    logic                   o_m_tvalid;
    logic                   i_m_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] o_m_tdata;
    logic                   o_m_tuser;
    logic                   i_cfg_valid = 1'b0;
    logic                   o_cfg_ready;
    logic [CFG_IDX_W-1:0]   i_cfg_index = '0;
    logic [DIST_W-1:0]      i_cfg_data = '0;

    int                     mismatch_count;
    int                     awaited_count;
    int                     items_sent = 0;
    int                     send_idle_pct = 0;
    int                     recv_stall_pct = 0;
    int                     hold_left = 0;
    int                     quiet_cycles = 0;
    logic [DIST_W-1:0]      clamp_now = CLAMP_LIMIT_RST;

    always #2 i_clk = ~i_clk;

    trimmed_mean_distance_filter_top dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tuser   (i_s_tuser),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tuser   (o_m_tuser),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    tmdf_output_check u_output_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_s_tvalid   (i_s_tvalid),
        .o_s_tready   (o_s_tready),
        .i_s_tdata    (i_s_tdata),
        .i_s_tuser    (i_s_tuser),
        .o_m_tvalid   (o_m_tvalid),
        .i_m_tready   (i_m_tready),
        .o_m_tdata    (o_m_tdata),
        .o_m_tuser    (o_m_tuser),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .o_mismatches (mismatch_count),
        .o_awaited    (awaited_count)
    );

    initial begin
        forever begin
            @(posedge i_clk);
            if (hold_left > 0) begin
                i_m_tready <= 1'b0;
                hold_left = hold_left - 1;
            end else begin
                i_m_tready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    initial begin
        while (quiet_cycles < QUIET_LIMIT) begin
            @(posedge i_clk);
            if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready)
                    || (i_cfg_valid && o_cfg_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("RESULT: ERROR");
        $finish;
    end

    task automatic send_reading(input logic [RAW_W-1:0] raw, input logic ok);
        while ($urandom_range(99) < send_idle_pct) begin
            i_s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata <= raw;
        i_s_tuser <= ok;
        do @(posedge i_clk); while (!o_s_tready);
        items_sent++;
    endtask

    task automatic write_register(input t_cfg_idx idx, input logic [DIST_W-1:0] value);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        if (idx == CFG_CLAMP_LIMIT)
            clamp_now = value;
    endtask

    task automatic write_all_registers(input logic [DIST_W-1:0] limit,
                                       input logic [DIST_W-1:0] subst,
                                       input logic [DIST_W-1:0] err,
                                       input logic [DIST_W-1:0] thresh,
                                       input logic [DIST_W-1:0] fails);
        write_register(CFG_CLAMP_LIMIT, limit);
        write_register(CFG_CLAMP_SUBST, subst);
        write_register(CFG_ERROR_DIST, err);
        write_register(CFG_NEAR_THRESH, thresh);
        write_register(CFG_FAIL_LIMIT, fails);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic wait_idle();
        i_s_tvalid <= 1'b0;
        @(posedge i_clk);
        while (awaited_count != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Mostly single readings; sometimes a run of readings around one level, so the
    // trimmed mean settles there, or a run of failed reads that drives the fault flag.
    task automatic random_burst();
        int               pick;
        int               n;
        int               v;
        int               base;
        logic [RAW_W-1:0] raw;
        pick = $urandom_range(99);
        if (pick < 4) begin
            base = $urandom_range(1023);
            n = 10 + $urandom_range(4);
            repeat (n) begin
                v = base + $urandom_range(6) - 3;
                if (v < 0) v = 0;
                raw = RAW_W'(v);
                send_reading(raw, 1'b1);
            end
        end else if (pick < 8) begin
            n = $urandom_range(17, 1);
            repeat (n) begin
                raw = RAW_W'($urandom);
                send_reading(raw, 1'b0);
            end
        end else begin
            pick = $urandom_range(99);
            if (pick < 45) begin
                raw = RAW_W'($urandom_range(1023));
            end else if (pick < 65) begin
                raw = RAW_W'($urandom);
            end else if (pick < 80) begin
                v = int'(clamp_now) + $urandom_range(4) - 2;
                if (v < 0) v = 0;
                raw = RAW_W'(v);
            end else begin
                raw = RAW_W'($urandom_range(300));
            end
            send_reading(raw, $urandom_range(99) >= 22);
        end
    endtask

    task automatic run_random(input int count, input int send_idle, input int recv_stall);
        int target;
        send_idle_pct = send_idle;
        recv_stall_pct = recv_stall;
        target = items_sent + count;
        while (items_sent < target) random_burst();
        wait_idle();
    endtask

    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_reading(16'd0, 1'b1);
        send_reading(16'd1000, 1'b1);
        send_reading(16'd1001, 1'b1);
        send_reading(16'hFFFF, 1'b1);
        repeat (6) send_reading(16'd0, 1'b1);
        send_reading(16'hFFFF, 1'b0);
        send_reading(16'h0000, 1'b0);
        repeat (4) send_reading(16'h5A5A, 1'b0);
        send_reading(16'd425, 1'b1);
        repeat (3) send_reading(16'hA5A5, 1'b0);
        send_reading(16'd1000, 1'b1);
        repeat (3) send_reading(16'd7, 1'b0);
        run_random(300, 0, 0);

        write_all_registers(10'd0, 10'd0, 10'd0, 10'd0, 10'd0);
        run_random(200, 73, 0);

        write_all_registers(10'd1023, 10'd1023, 10'd1023, 10'd1023, 10'h3FF);
        run_random(300, 0, 73);

        write_all_registers(DIST_W'($urandom_range(1023)), DIST_W'($urandom_range(1023)),
                            DIST_W'($urandom_range(1023)), DIST_W'($urandom_range(1023)),
                            DIST_W'($urandom_range(1023)));
        hold_left = HOLD_CYCLES;
        run_random(300, 8, 8);

        write_all_registers(DIST_W'($urandom_range(700, 300)), DIST_W'($urandom_range(1023)),
                            DIST_W'($urandom_range(1023)), DIST_W'($urandom_range(600, 200)),
                            DIST_W'($urandom_range(15)));
        run_random(280, 0, 0);

        if (mismatch_count == 0 && awaited_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
